// ===== rtl/tss_pkg.sv =====
// Package for the tone score stream splitter.
// Holds parser states, routing kinds, opcode constants and the queue entry type.
// No dependencies; used by every module of the block.
package tss_pkg;

  localparam int QueueDepth = 2;

  // Opcode nibbles (upper four bits of a command byte)
  localparam logic [3:0] OpNoteOff = 4'h8;
  localparam logic [3:0] OpNoteOn  = 4'h9;
  localparam logic [3:0] OpInstr   = 4'hC;
  localparam logic [3:0] OpRestart = 4'hE;
  localparam logic [3:0] OpStop    = 4'hF;

  localparam logic [7:0] HdrMagicP   = 8'h50;
  localparam logic [7:0] HdrMagicT   = 8'h74;
  localparam logic [7:0] HdrMinLen   = 8'd6;
  localparam logic [7:0] HdrLenIdx   = 8'd2;
  localparam logic [7:0] HdrFlagIdx  = 8'd3;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_AFTER_P,
    PH_HEADER,
    PH_CMD,
    PH_WAIT2,
    PH_NOTE,
    PH_VOLUME,
    PH_INSTR
  } phase_t;

  typedef enum logic [1:0] {
    RK_ALL,
    RK_GEN,
    RK_NOTE
  } route_kind_t;

  typedef struct packed {
    route_kind_t kind;
    logic [3:0]  gen;
    logic [7:0]  value;
  } route_tag_t;

endpackage

// ===== rtl/tss_if.sv =====
// Valid/ready channel interfaces for the tone score stream splitter.
// tss_in_if carries score bytes in, tss_out_if carries routed bytes out.
// No dependencies.
interface tss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] score_byte;
  logic       score_first;

  modport source (output valid, output score_byte, output score_first, input ready);
  modport sink   (input valid, input score_byte, input score_first, output ready);
endinterface

interface tss_out_if;
  logic       valid;
  logic       ready;
  logic       to_all;
  logic [3:0] generator;
  logic [7:0] value;
  logic       is_note;

  modport source (output valid, output to_all, output generator, output value,
                  output is_note, input ready);
  modport sink   (input valid, input to_all, input generator, input value,
                  input is_note, output ready);
endinterface

// ===== rtl/tss_front.sv =====
// Front end: accepts score bytes, tracks the parser state and classifies each byte.
// Pushes a route tag into the queue for every byte that produces a transaction.
// Depends on tss_pkg and tss_in_if.
module tss_front (
  input  logic                clk,
  input  logic                rst,
  tss_in_if.sink              score,
  input  logic                full,
  output logic                push,
  output tss_pkg::route_tag_t tag
);

  tss_pkg::phase_t phase, phase_next;
  logic [7:0]      header_count, header_count_next;
  logic [7:0]      header_total, header_total_next;
  logic            volume_on, volume_on_next;
  logic [3:0]      pending_generator, pending_generator_next;
  logic            halted, halted_next;

  // State as seen by this byte (a score start restarts the parser)
  tss_pkg::phase_t e_phase;
  logic [7:0]      e_count, e_total;
  logic            e_volume, e_halted;
  logic [3:0]      e_pending;

  // Command decode
  logic                  cmd_emit, cmd_halt, cmd_pend;
  tss_pkg::route_kind_t  cmd_kind;
  tss_pkg::phase_t       cmd_phase;

  logic       accept;
  logic [7:0] b;
  logic [7:0] len;
  logic [7:0] count_inc;
  logic       emit;

  assign score.ready = !full;
  assign accept      = score.valid && score.ready;
  assign b           = score.score_byte;

  always_comb begin
    if (score.score_first) begin
      e_phase   = tss_pkg::PH_FIRST;
      e_count   = '0;
      e_total   = tss_pkg::HdrMinLen;
      e_volume  = 1'b0;
      e_pending = '0;
      e_halted  = 1'b0;
    end else begin
      e_phase   = phase;
      e_count   = header_count;
      e_total   = header_total;
      e_volume  = volume_on;
      e_pending = pending_generator;
      e_halted  = halted;
    end
  end

  always_comb begin
    cmd_emit  = 1'b0;
    cmd_halt  = 1'b0;
    cmd_pend  = 1'b0;
    cmd_kind  = tss_pkg::RK_ALL;
    cmd_phase = tss_pkg::PH_CMD;
    if (!b[7]) begin
      // wait: two bytes broadcast
      cmd_emit  = 1'b1;
      cmd_phase = tss_pkg::PH_WAIT2;
    end else begin
      case (b[7:4]) inside
        tss_pkg::OpNoteOff: begin
          cmd_emit = 1'b1;
          cmd_kind = tss_pkg::RK_GEN;
        end
        tss_pkg::OpNoteOn: begin
          cmd_emit  = 1'b1;
          cmd_kind  = tss_pkg::RK_GEN;
          cmd_pend  = 1'b1;
          cmd_phase = tss_pkg::PH_NOTE;
        end
        tss_pkg::OpInstr: begin
          cmd_phase = tss_pkg::PH_INSTR;
        end
        tss_pkg::OpRestart, tss_pkg::OpStop: begin
          cmd_emit = 1'b1;
          cmd_halt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    phase_next             = e_phase;
    header_count_next      = e_count;
    header_total_next      = e_total;
    volume_on_next         = e_volume;
    pending_generator_next = e_pending;
    halted_next            = e_halted;
    emit                   = 1'b0;
    tag.kind               = tss_pkg::RK_ALL;
    tag.gen                = '0;
    tag.value              = b;
    len                    = (b < tss_pkg::HdrMinLen) ? tss_pkg::HdrMinLen : b;
    count_inc              = e_count + 8'd1;

    if (!e_halted) begin
      unique case (e_phase)
        tss_pkg::PH_FIRST, tss_pkg::PH_CMD: begin
          if (e_phase == tss_pkg::PH_FIRST && b == tss_pkg::HdrMagicP) begin
            header_count_next = 8'd1;
            phase_next        = tss_pkg::PH_AFTER_P;
            emit              = 1'b1;
          end else begin
            phase_next  = cmd_phase;
            halted_next = cmd_halt;
            emit        = cmd_emit;
            tag.kind    = cmd_kind;
            if (cmd_kind == tss_pkg::RK_GEN) tag.gen = b[3:0];
            if (cmd_pend) pending_generator_next = b[3:0];
          end
        end
        tss_pkg::PH_AFTER_P: begin
          emit = 1'b1;
          if (b == tss_pkg::HdrMagicT) begin
            header_count_next = 8'd2;
            phase_next        = tss_pkg::PH_HEADER;
          end else begin
            phase_next = tss_pkg::PH_CMD;
          end
        end
        tss_pkg::PH_HEADER: begin
          emit = 1'b1;
          if (e_count == tss_pkg::HdrLenIdx) header_total_next = len;
          else if (e_count == tss_pkg::HdrFlagIdx) volume_on_next = b[7];
          header_count_next = count_inc;
          if (count_inc >= header_total_next) phase_next = tss_pkg::PH_CMD;
        end
        tss_pkg::PH_WAIT2: begin
          emit       = 1'b1;
          phase_next = tss_pkg::PH_CMD;
        end
        tss_pkg::PH_NOTE: begin
          emit       = 1'b1;
          tag.kind   = tss_pkg::RK_NOTE;
          tag.gen    = e_pending;
          phase_next = e_volume ? tss_pkg::PH_VOLUME : tss_pkg::PH_CMD;
        end
        tss_pkg::PH_VOLUME, tss_pkg::PH_INSTR: begin
          phase_next = tss_pkg::PH_CMD;
        end
        default: begin
          phase_next = tss_pkg::PH_CMD;
        end
      endcase
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= tss_pkg::PH_FIRST;
      header_count      <= '0;
      header_total      <= tss_pkg::HdrMinLen;
      volume_on         <= 1'b0;
      pending_generator <= '0;
      halted            <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      header_count      <= header_count_next;
      header_total      <= header_total_next;
      volume_on         <= volume_on_next;
      pending_generator <= pending_generator_next;
      halted            <= halted_next;
    end
  end

  // a halted parser drops everything until the next score start
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (halted && !score.score_first) |-> !push)
    else $error("tss_front: transaction pushed while halted");

  // a score start can never land on a note byte
  a_first_no_note: assert property (@(posedge clk) disable iff (rst)
    (push && score.score_first) |-> (tag.kind != tss_pkg::RK_NOTE))
    else $error("tss_front: note tagged on first byte of a score");

endmodule

// ===== rtl/tss_queue.sv =====
// Short FIFO of route tags between the front and back ends.
// Flop-based storage, one push and one pop per cycle; pushes are refused while full.
// Depends on tss_pkg.
module tss_queue #(
  parameter int Depth = tss_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tss_pkg::route_tag_t push_tag,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output tss_pkg::route_tag_t head_tag
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  tss_pkg::route_tag_t entries [Depth];
  logic [PtrW-1:0] wptr, rptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_tag   = entries[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wptr] <= push_tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + PtrW'(1);
      if (do_pop)  rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + PtrW'(1);
      if (do_push && !do_pop)      count <= count + CntW'(1);
      else if (!do_push && do_pop) count <= count - CntW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("tss_queue: push into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("tss_queue: occupancy out of range");

endmodule

// ===== rtl/tss_back.sv =====
// Back end: pops route tags and drives the registered output transaction.
// Expands the tag kind into to_all, generator and is_note.
// Depends on tss_pkg and tss_out_if.
module tss_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  tss_pkg::route_tag_t head_tag,
  output logic                pop,
  tss_out_if.source           route
);

  logic       valid;
  logic       to_all;
  logic [3:0] generator;
  logic [7:0] value;
  logic       is_note;

  assign pop = head_valid && (!valid || route.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!valid || route.ready) begin
      valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      to_all    <= (head_tag.kind == tss_pkg::RK_ALL);
      generator <= (head_tag.kind == tss_pkg::RK_ALL) ? 4'd0 : head_tag.gen;
      value     <= head_tag.value;
      is_note   <= (head_tag.kind == tss_pkg::RK_NOTE);
    end
  end

  assign route.valid     = valid;
  assign route.to_all    = to_all;
  assign route.generator = generator;
  assign route.value     = value;
  assign route.is_note   = is_note;

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> valid)
    else $error("tss_back: popped tag did not reach the output");

endmodule

// ===== rtl/tone_score_stream_splitter.sv =====
// Tone score stream splitter, top level.
// score (sink): one score byte per transaction, score_first restarts the parser.
// route (source): one routed byte per transaction: broadcast or one generator,
//   with is_note marking the note byte of a play command.
// Bytes that are skipped (instrument commands and their arguments, volume arguments,
//   undefined opcodes, anything after stop or restart) give no output transaction.
// Throughput: one byte per cycle sustained while route.ready stays high; the parser
//   state register updates on each accepted byte.
// Path: a routed byte is registered in the tag queue and then in the output
//   register before it shows on route.
// Stalls: the tag queue (QueueDepth entries) absorbs back-pressure; score.ready
//   drops only when the queue is full. The output holds while route.ready is low.
// Reset (rst, synchronous): parser returns to expecting a first score byte,
//   queue empties and route.valid falls. Without score_first, the first byte
//   after reset starts a score.
// Depends on tss_pkg, tss_if, tss_front, tss_queue and tss_back.
module tone_score_stream_splitter #(
  parameter int QueueDepth = tss_pkg::QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  tss_in_if.sink    score,
  tss_out_if.source route
);

  logic                full;
  logic                push;
  tss_pkg::route_tag_t push_tag;
  logic                pop;
  logic                head_valid;
  tss_pkg::route_tag_t head_tag;

  tss_front u_front (
    .clk   (clk),
    .rst   (rst),
    .score (score),
    .full  (full),
    .push  (push),
    .tag   (push_tag)
  );

  tss_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_tag   (push_tag),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tag   (head_tag)
  );

  tss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_tag   (head_tag),
    .pop        (pop),
    .route      (route)
  );

endmodule

// ===== dv/tb.sv =====
// Testbench for tone_score_stream_splitter: random and directed score bytestreams
// with idle and stall phases, checked against a behavioural scoreboard class.
// Depends on rtl/tss_pkg.sv, rtl/tss_if.sv and the RTL of the block.
module tb;

  // Opcode groups the parser does not define
  localparam logic [3:0] OpUndefA = 4'hA;
  localparam logic [3:0] OpUndefB = 4'hB;
  localparam logic [3:0] OpUndefD = 4'hD;

  typedef struct packed {
    logic       to_all;
    logic [3:0] generator;
    logic [7:0] value;
    logic       is_note;
  } routed_byte_t;

  class route_scoreboard;
    tss_pkg::phase_t phase;
    logic [7:0]      hdr_count;
    logic [7:0]      hdr_len;
    logic            vol_on;
    logic [3:0]      note_gen;
    logic            halted;
    routed_byte_t    expected_routes[$];
    int              mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      phase     = tss_pkg::PH_FIRST;
      hdr_count = 8'd0;
      hdr_len   = tss_pkg::HdrMinLen;
      vol_on    = 1'b0;
      note_gen  = 4'd0;
      halted    = 1'b0;
    endfunction

    function int pending();
      return expected_routes.size();
    endfunction

    function void emit(logic all, logic [3:0] g, logic [7:0] v, logic n);
      routed_byte_t r;
      r = '{all, g, v, n};
      expected_routes = {expected_routes, r};
    endfunction

    function void decode_command(logic [7:0] b);
      if (b < 8'h80) begin
        phase = tss_pkg::PH_WAIT2;
        emit(1'b1, 4'd0, b, 1'b0);
      end else begin
        case (b[7:4])
          tss_pkg::OpNoteOff: emit(1'b0, b[3:0], b, 1'b0);
          tss_pkg::OpNoteOn: begin
            note_gen = b[3:0];
            phase    = tss_pkg::PH_NOTE;
            emit(1'b0, b[3:0], b, 1'b0);
          end
          tss_pkg::OpInstr: phase = tss_pkg::PH_INSTR;
          tss_pkg::OpRestart, tss_pkg::OpStop: begin
            halted = 1'b1;
            emit(1'b1, 4'd0, b, 1'b0);
          end
          default: ;
        endcase
      end
    endfunction

    // Work out where an accepted score byte is routed, if anywhere
    function void route_byte(logic [7:0] b, logic first);
      if (first) restart();
      if (halted) return;
      case (phase)
        tss_pkg::PH_FIRST: begin
          if (b == tss_pkg::HdrMagicP) begin
            hdr_count = 8'd1;
            phase     = tss_pkg::PH_AFTER_P;
            emit(1'b1, 4'd0, b, 1'b0);
          end else begin
            phase = tss_pkg::PH_CMD;
            decode_command(b);
          end
        end
        tss_pkg::PH_AFTER_P: begin
          // a lone 'P' is a wait, so this byte is its second half
          if (b == tss_pkg::HdrMagicT) begin
            hdr_count = 8'd2;
            phase     = tss_pkg::PH_HEADER;
          end else begin
            phase = tss_pkg::PH_CMD;
          end
          emit(1'b1, 4'd0, b, 1'b0);
        end
        tss_pkg::PH_HEADER: begin
          if (hdr_count == tss_pkg::HdrLenIdx)
            hdr_len = (b < tss_pkg::HdrMinLen) ? tss_pkg::HdrMinLen : b;
          else if (hdr_count == tss_pkg::HdrFlagIdx) vol_on = b[7];
          hdr_count = hdr_count + 8'd1;
          if (hdr_count >= hdr_len) phase = tss_pkg::PH_CMD;
          emit(1'b1, 4'd0, b, 1'b0);
        end
        tss_pkg::PH_WAIT2: begin
          phase = tss_pkg::PH_CMD;
          emit(1'b1, 4'd0, b, 1'b0);
        end
        tss_pkg::PH_NOTE: begin
          phase = vol_on ? tss_pkg::PH_VOLUME : tss_pkg::PH_CMD;
          emit(1'b0, note_gen, b, 1'b1);
        end
        tss_pkg::PH_VOLUME, tss_pkg::PH_INSTR: phase = tss_pkg::PH_CMD;
        default: begin
          phase = tss_pkg::PH_CMD;
          decode_command(b);
        end
      endcase
    endfunction

    function void check_route(routed_byte_t got);
      routed_byte_t want;
      if (expected_routes.size() == 0) begin
        $error("unexpected routed byte: value %h to_all %0d", got.value, got.to_all);
        mismatches++;
        return;
      end
      want = expected_routes.pop_front();
      if (got.to_all !== want.to_all) begin
        $error("to_all: expected %0d, got %0d", want.to_all, got.to_all);
        mismatches++;
      end
      if (got.generator !== want.generator) begin
        $error("generator: expected %0d, got %0d", want.generator, got.generator);
        mismatches++;
      end
      if (got.value !== want.value) begin
        $error("value: expected %h, got %h", want.value, got.value);
        mismatches++;
      end
      if (got.is_note !== want.is_note) begin
        $error("is_note: expected %0d, got %0d", want.is_note, got.is_note);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  tss_in_if  score_ch ();
  tss_out_if route_ch ();

  tone_score_stream_splitter DUT (
    .clk  (clk),
    .rst  (rst),
    .score(score_ch),
    .route(route_ch)
  );

  route_scoreboard sb = new();
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int live_items     = 0;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    route_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Transactions are sampled at the edge, before the block's own updates land
  always @(posedge clk) begin
    if (!rst) begin
      if (score_ch.valid && score_ch.ready)
        sb.route_byte(score_ch.score_byte, score_ch.score_first);
      if (route_ch.valid && route_ch.ready)
        sb.check_route(routed_byte_t'{route_ch.to_all, route_ch.generator,
                                      route_ch.value, route_ch.is_note});
    end
  end

  task automatic send_item(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < src_idle_pct) begin
      score_ch.valid <= 1'b0;
      @(posedge clk);
    end
    score_ch.valid       <= 1'b1;
    score_ch.score_byte  <= b;
    score_ch.score_first <= first;
    @(posedge clk);
    while (!score_ch.ready) @(posedge clk);
    live_items++;
  endtask

  // Hold off the sender until every routed byte has been seen
  task automatic drain();
    score_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_command(input logic vol, input logic first);
    int         kind;
    logic [3:0] g;
    logic [3:0] undef_op;
    kind = $urandom_range(99);
    g    = 4'($urandom);
    if (kind < 25) begin
      send_item(8'($urandom_range(8'h7f)), first);
      send_item(8'($urandom), 1'b0);
    end else if (kind < 45) begin
      send_item({tss_pkg::OpNoteOn, g}, first);
      send_item(8'($urandom), 1'b0);
      if (vol) send_item(8'($urandom), 1'b0);
    end else if (kind < 65) begin
      send_item({tss_pkg::OpNoteOff, g}, first);
    end else if (kind < 78) begin
      send_item({tss_pkg::OpInstr, g}, first);
      send_item(8'($urandom), 1'b0);
    end else if (kind < 88) begin
      case ($urandom_range(2))
        0:       undef_op = OpUndefA;
        1:       undef_op = OpUndefB;
        default: undef_op = OpUndefD;
      endcase
      send_item({undef_op, g}, first);
    end else begin
      send_item(8'($urandom), first);
    end
  endtask

  task automatic send_score(input int n_cmds);
    int         pick;
    int         k;
    int         n;
    logic       vol;
    logic [7:0] len;
    logic [7:0] flags;
    logic [7:0] b;
    vol  = 1'b0;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_item(tss_pkg::HdrMagicP, 1'b1);
      send_item(tss_pkg::HdrMagicT, 1'b0);
      // mostly short headers, now and then a long one
      len = ($urandom_range(29) == 0) ? 8'($urandom) : 8'($urandom_range(12));
      send_item(len, 1'b0);
      flags = 8'($urandom);
      vol   = flags[7];
      send_item(flags, 1'b0);
      for (k = 4; k < ((len < tss_pkg::HdrMinLen) ? tss_pkg::HdrMinLen : len); k++)
        send_item(8'($urandom), 1'b0);
    end else if (pick < 70) begin
      b = 8'($urandom);
      if (b == tss_pkg::HdrMagicT) b = b + 8'd1;
      send_item(tss_pkg::HdrMagicP, 1'b1);
      send_item(b, 1'b0);
    end else begin
      send_command(vol, 1'b1);
    end
    for (k = 0; k < n_cmds; k++) send_command(vol, 1'b0);
    if ($urandom_range(99) < 40) begin
      send_item({($urandom_range(1) ? tss_pkg::OpStop : tss_pkg::OpRestart),
                 4'($urandom)}, 1'b0);
      n = $urandom_range(4);
      for (k = 0; k < n; k++) send_item(8'($urandom), 1'b0);
      live_items -= n;
    end
  endtask

  initial begin
    int ph;
    int target;
    rst                  <= 1'b1;
    score_ch.valid       <= 1'b0;
    score_ch.score_byte  <= 8'd0;
    score_ch.score_first <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // first byte after reset without score_first
    send_item(8'h93, 1'b0);
    send_item(8'h00, 1'b0);
    // header with short length and volume flag set
    send_item(tss_pkg::HdrMagicP, 1'b1);
    send_item(tss_pkg::HdrMagicT, 1'b0);
    send_item(8'h03, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h10, 1'b0);
    send_item(8'h9F, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hC3, 1'b0);
    send_item(8'h12, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item({OpUndefA, 4'h0}, 1'b0);
    send_item({OpUndefB, 4'hF}, 1'b0);
    send_item({OpUndefD, 4'h5}, 1'b0);
    send_item({tss_pkg::OpStop, 4'hE}, 1'b0);
    send_item(8'h55, 1'b0);
    // leading 'P' without 't', then restart
    send_item(tss_pkg::HdrMagicP, 1'b1);
    send_item(8'h20, 1'b0);
    send_item({tss_pkg::OpRestart, 4'h0}, 1'b0);
    send_item(8'h7F, 1'b0);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 71; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 71; end
        default: begin src_idle_pct = 9;  sink_stall_pct = 9;  end
      endcase
      target = live_items + 100;
      while (live_items < target) send_score($urandom_range(3, 20));
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: done, errors");
    $finish;
  end
endmodule

// ===== tone_score_stream_splitter.f =====
rtl/tss_pkg.sv
rtl/tss_if.sv
rtl/tss_front.sv
rtl/tss_queue.sv
rtl/tss_back.sv
rtl/tone_score_stream_splitter.sv
dv/tb.sv
